// File: sv/pngunp_pkg.sv
// Shared types, codes and constants for the PNG scanline pixel unpacker.
package pngunp_pkg;

   localparam int MAX_WIDTH_DEF     = 4096;
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int COL_W             = 13;   // row_width register width
   localparam int ADDR_W            = 4;    // three 32-bit registers
   localparam int QUEUE_DEPTH       = 4;    // power of two

   // color_mode codes
   localparam logic [2:0] MODE_GREY       = 3'd0;
   localparam logic [2:0] MODE_GREY_ALPHA = 3'd1;
   localparam logic [2:0] MODE_PALETTE    = 3'd2;
   localparam logic [2:0] MODE_RGB        = 3'd3;
   localparam logic [2:0] MODE_RGBA       = 3'd4;

   // depth_code codes
   localparam logic [2:0] DEPTH_1  = 3'd0;
   localparam logic [2:0] DEPTH_2  = 3'd1;
   localparam logic [2:0] DEPTH_4  = 3'd2;
   localparam logic [2:0] DEPTH_8  = 3'd3;
   localparam logic [2:0] DEPTH_16 = 3'd4;

   // register indexes
   localparam logic [1:0] REG_COLOR_MODE = 2'd0;
   localparam logic [1:0] REG_DEPTH_CODE = 2'd1;
   localparam logic [1:0] REG_ROW_WIDTH  = 2'd2;

   // input item kinds
   localparam logic KIND_PAL_WRITE = 1'b0;
   localparam logic KIND_DATA      = 1'b1;

   // work queued from front to back
   typedef enum logic [2:0] {
      OP_PAL_WR,     // data = {index, red, green, blue}
      OP_PIX,        // data = {red, green, blue, alpha}
      OP_PIX_LUT,    // data[7:0] = palette index
      OP_BITS,       // data[7:0] = packed grey samples
      OP_BITS_LUT    // data[7:0] = packed palette indices
   } pngunp_op_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] pal_index;
      logic [7:0] pal_red;
      logic [7:0] pal_green;
      logic [7:0] pal_blue;
   } pngunp_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       row_end;
      logic       burst_end;
   } pngunp_rsp_type;

   typedef struct packed {
      pngunp_op_type op;
      logic [31:0]   data;
   } pngunp_entry_type;

   typedef struct packed {
      logic [2:0] color_mode;
      logic [2:0] depth_code;
   } pngunp_front_cfg_type;

   typedef struct packed {
      logic [2:0]       depth_code;
      logic [COL_W-1:0] eff_width;
   } pngunp_back_cfg_type;

endpackage

// File: sv/png_scanline_pixel_unpack_core.sv
// Top level of the PNG scanline pixel unpacker: register port, front end, queue, back end.
//
// Turns decoded PNG scanline bytes into 8-bit RGBA pixels, one result transaction per
// pixel, with row_end on the last pixel of each scanline and burst_end on the last pixel
// caused by an input byte. Request transactions are either palette writes (kind 0) or
// scanline bytes (kind 1); both pass in order through a 4-entry queue, so a palette write
// never overtakes a lookup that precedes it. The front end takes one request per cycle
// whenever the queue has room, even while a finished pixel waits at rsp; bytes of 8- and
// 16-bit pixels are gathered there at one byte per cycle. The back end emits at most one
// pixel per cycle from its output register, and only while it is free; a packed byte
// holds the queue head until all its pixels are out: up to 8 at 1-bit depth, 4 at 2-bit,
// 2 at 4-bit. Palette writes yield no pixel. The palette is a RAM with a registered read
// and a per-entry valid bit cleared by reset, so entries not yet written read as zero
// and there is no clearing pass after reset. Unsupported mode/depth combinations drop
// data bytes silently. Writing any register restarts the scanline; write registers only
// while no transaction is in flight. Registers: 0x0 color_mode, 0x4 depth_code,
// 0x8 row_width (0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH).
module png_scanline_pixel_unpack_core import pngunp_pkg::*; #(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  pngunp_req_type    req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pngunp_rsp_type    rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [16:0] MAX_W = 17'(MAX_WIDTH);

   // config registers
   logic [2:0]       color_mode_ff, color_mode_in;
   logic [2:0]       depth_code_ff, depth_code_in;
   logic [COL_W-1:0] row_width_ff, row_width_in;
   logic [COL_W-1:0] eff_width;
   logic [1:0]       reg_idx;
   logic             wr_strobe, restart;

   pngunp_front_cfg_type front_cfg;
   pngunp_back_cfg_type  back_cfg;

   logic             q_push, q_pop, q_full, q_head_vld;
   pngunp_entry_type q_entry, q_head;
   logic [COL_W-1:0] column;

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      color_mode_in = color_mode_ff;
      depth_code_in = depth_code_ff;
      row_width_in  = row_width_ff;
      restart       = 1'b0;
      prdata        = 32'b0;
      if (wr_strobe) begin
         case (reg_idx)
            REG_COLOR_MODE: begin
               color_mode_in = pwdata[2:0];
               restart       = 1'b1;
            end
            REG_DEPTH_CODE: begin
               depth_code_in = pwdata[2:0];
               restart       = 1'b1;
            end
            REG_ROW_WIDTH: begin
               row_width_in = pwdata[COL_W-1:0];
               restart      = 1'b1;
            end
            default: ;   // unmapped: ignored, no restart
         endcase
      end
      case (reg_idx)
         REG_COLOR_MODE: prdata = {29'b0, color_mode_ff};
         REG_DEPTH_CODE: prdata = {29'b0, depth_code_ff};
         REG_ROW_WIDTH:  prdata = {{(32-COL_W){1'b0}}, row_width_ff};
         default:        prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_GREY;
         depth_code_ff <= DEPTH_8;
         row_width_ff  <= COL_W'(1);
      end else begin
         color_mode_ff <= color_mode_in;
         depth_code_ff <= depth_code_in;
         row_width_ff  <= row_width_in;
      end
   end

   // clamp the row width once for the back end
   always_comb begin
      if (row_width_ff == '0) begin
         eff_width = COL_W'(1);
      end else if ({4'b0, row_width_ff} > MAX_W) begin
         eff_width = COL_W'(MAX_WIDTH);
      end else begin
         eff_width = row_width_ff;
      end
   end

   assign front_cfg = '{color_mode: color_mode_ff, depth_code: depth_code_ff};
   assign back_cfg  = '{depth_code: depth_code_ff, eff_width: eff_width};

   // ---------------------------------------------------------------- datapath
   pngunp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .cfg       (front_cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   pngunp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .head_vld   (q_head_vld),
      .full       (q_full)
   );

   pngunp_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .cfg       (back_cfg),
      .head      (q_head),
      .head_vld  (q_head_vld),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .column    (column)
   );

   // ---------------------------------------------------------------- assertions
   // a scanline always ends the pixel burst of its byte
   a_row_end_closes_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_end |-> rsp_data.burst_end)
      else $error("row_end without burst_end");

   // column counter stays inside the current row
   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      column < eff_width)
      else $error("column count reached row width");

   // nothing is presented straight out of reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: sv/pngunp_front.sv
// Front end: accepts transactions, gathers multi-byte pixels, queues work for the back end.
module pngunp_front import pngunp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  pngunp_front_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pngunp_req_type       req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output pngunp_entry_type     q_entry
);

   logic [55:0] hold_ff, hold_in;
   logic [2:0]  phase_ff, phase_in;
   logic [63:0] seq;
   logic [7:0]  sel [4];
   logic [3:0]  bpp;
   logic        narrow_ok, wide_ok, wide16, accept;
   logic [31:0] pix;
   logic        pix_lut;

   // floor(w / 257): high byte, less one when the low byte is below it
   function automatic logic [7:0] div257(input logic [15:0] w);
      return (w[7:0] >= w[15:8]) ? w[15:8] : w[15:8] - 8'd1;
   endfunction

   assign seq    = {hold_ff, req_data.data_byte};
   assign wide16 = (cfg.depth_code == DEPTH_16);

   // channel j counted from the last byte/word received
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sel[j] = wide16 ? div257(seq[16*j +: 16]) : seq[8*j +: 8];
      end
   end

   always_comb begin
      narrow_ok = (cfg.depth_code == DEPTH_1 || cfg.depth_code == DEPTH_2 ||
                   cfg.depth_code == DEPTH_4) &&
                  (cfg.color_mode == MODE_GREY || cfg.color_mode == MODE_PALETTE);
      wide_ok   = (cfg.depth_code == DEPTH_8 || cfg.depth_code == DEPTH_16) &&
                  (cfg.color_mode <= MODE_RGBA) &&
                  !(cfg.color_mode == MODE_PALETTE && wide16);
      pix_lut = 1'b0;
      case (cfg.color_mode)
         MODE_GREY: begin
            bpp = wide16 ? 4'd2 : 4'd1;
            pix = {sel[0], sel[0], sel[0], 8'hFF};
         end
         MODE_GREY_ALPHA: begin
            bpp = wide16 ? 4'd4 : 4'd2;
            pix = {sel[1], sel[1], sel[1], sel[0]};
         end
         MODE_PALETTE: begin
            bpp     = 4'd1;
            pix     = {24'b0, sel[0]};
            pix_lut = 1'b1;
         end
         MODE_RGB: begin
            bpp = wide16 ? 4'd6 : 4'd3;
            pix = {sel[2], sel[1], sel[0], 8'hFF};
         end
         MODE_RGBA: begin
            bpp = wide16 ? 4'd8 : 4'd4;
            pix = {sel[3], sel[2], sel[1], sel[0]};
         end
         default: begin
            bpp = 4'd1;
            pix = 32'b0;
         end
      endcase
   end

   always_comb begin
      req_ready = !q_full;
      accept    = req_valid && req_ready;
      hold_in   = hold_ff;
      phase_in  = phase_ff;
      q_push    = 1'b0;
      q_entry   = '{op: OP_PIX, data: 32'b0};
      if (restart) begin
         hold_in  = '0;
         phase_in = '0;
      end else if (accept) begin
         if (req_data.kind == KIND_PAL_WRITE) begin
            q_push  = 1'b1;
            q_entry = '{op: OP_PAL_WR,
                        data: {req_data.pal_index, req_data.pal_red,
                               req_data.pal_green, req_data.pal_blue}};
         end else if (narrow_ok) begin
            q_push  = 1'b1;
            q_entry = '{op: (cfg.color_mode == MODE_PALETTE) ? OP_BITS_LUT : OP_BITS,
                        data: {24'b0, req_data.data_byte}};
         end else if (wide_ok) begin
            if ({1'b0, phase_ff} + 4'd1 < bpp) begin
               hold_in  = seq[55:0];
               phase_in = phase_ff + 3'd1;
            end else begin
               q_push   = 1'b1;
               q_entry  = '{op: pix_lut ? OP_PIX_LUT : OP_PIX, data: pix};
               hold_in  = '0;
               phase_in = '0;
            end
         end
         // unsupported mode/depth: byte dropped, nothing changes
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         phase_ff <= '0;
      end else begin
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: sv/pngunp_queue.sv
// Small flip-flop FIFO between front and back ends.
module pngunp_queue import pngunp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pngunp_entry_type push_entry,
   input  logic             pop,
   output pngunp_entry_type head,
   output logic             head_vld,
   output logic             full
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pngunp_entry_type slot_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign head     = slot_ff[rd_ff];
   assign head_vld = (cnt_ff != '0);
   assign full     = (cnt_ff == CW'(QUEUE_DEPTH));

   // depth is a power of two, pointers wrap naturally
   always_comb begin
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/pngunp_back.sv
// Back end: palette store, per-pixel unpack and column tracking, result register.
module pngunp_back import pngunp_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  pngunp_back_cfg_type cfg,
   input  pngunp_entry_type    head,
   input  logic                head_vld,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pngunp_rsp_type      rsp_data,
   output logic [COL_W-1:0]    column
);

   localparam int PAW = $clog2(PALETTE_DEPTH);

   logic [23:0]              pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff, pal_vld_in;

   logic [2:0]       k_ff, k_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic        b_vld_ff, b_vld_in;
   logic        b_lut_ff, b_row_end_ff, b_burst_end_ff;
   logic [31:0] b_pix_ff;
   logic [23:0] rd_ff, lut_rgb;
   logic        rd_ok_ff;

   logic           b_free, emit, pal_wr, is_bits, is_lut, last_k, row_end, burst_end;
   logic [2:0]     shamt;
   logic [7:0]     shifted, sample, grey, lut_idx;
   logic [31:0]    pix;
   logic [PAW-1:0] wr_addr, rd_addr;
   logic           wr_in_range, rd_in_range;

   assign column = col_ff;

   // sample k of a packed byte, MSB first
   always_comb begin
      shamt   = 3'(k_ff << cfg.depth_code);
      shifted = head.data[7:0] << shamt;
      case (cfg.depth_code)
         DEPTH_1: begin
            sample = {7'b0, shifted[7]};
            grey   = {8{shifted[7]}};
            last_k = (k_ff == 3'd7);
         end
         DEPTH_2: begin
            sample = {6'b0, shifted[7:6]};
            grey   = {4{shifted[7:6]}};
            last_k = (k_ff == 3'd3);
         end
         DEPTH_4: begin
            sample = {4'b0, shifted[7:4]};
            grey   = {2{shifted[7:4]}};
            last_k = (k_ff == 3'd1);
         end
         default: begin
            sample = 8'b0;
            grey   = 8'b0;
            last_k = 1'b1;
         end
      endcase
   end

   always_comb begin
      is_bits   = (head.op == OP_BITS) || (head.op == OP_BITS_LUT);
      is_lut    = (head.op == OP_PIX_LUT) || (head.op == OP_BITS_LUT);
      b_free    = !b_vld_ff || rsp_ready;
      pal_wr    = head_vld && (head.op == OP_PAL_WR);
      emit      = head_vld && (head.op != OP_PAL_WR) && b_free;
      row_end   = ({1'b0, col_ff} + 14'd1) >= {1'b0, cfg.eff_width};
      burst_end = !is_bits || last_k || row_end;
      pop       = pal_wr || (emit && burst_end);

      lut_idx = (head.op == OP_BITS_LUT) ? sample : head.data[7:0];
      case (head.op)
         OP_BITS: pix = {grey, grey, grey, 8'hFF};
         OP_PIX:  pix = head.data;
         default: pix = {24'b0, 8'hFF};
      endcase

      wr_addr     = head.data[24 +: PAW];
      wr_in_range = {1'b0, head.data[31:24]} < 9'(PALETTE_DEPTH);
      rd_addr     = lut_idx[PAW-1:0];
      rd_in_range = {1'b0, lut_idx} < 9'(PALETTE_DEPTH);

      pal_vld_in = pal_vld_ff;
      if (pal_wr && wr_in_range) begin
         pal_vld_in[wr_addr] = 1'b1;
      end

      k_in   = k_ff;
      col_in = col_ff;
      if (restart) begin
         k_in   = '0;
         col_in = '0;
      end else if (emit) begin
         k_in   = burst_end ? 3'd0 : k_ff + 3'd1;
         col_in = row_end ? '0 : col_ff + COL_W'(1);
      end

      b_vld_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : b_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
         k_ff       <= '0;
         col_ff     <= '0;
         b_vld_ff   <= 1'b0;
      end else begin
         pal_vld_ff <= pal_vld_in;
         k_ff       <= k_in;
         col_ff     <= col_in;
         b_vld_ff   <= b_vld_in;
      end
   end

   // palette RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pal_wr && wr_in_range) begin
         pal_mem[wr_addr] <= head.data[23:0];
      end
      if (emit) begin
         rd_ff <= pal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rd_ok_ff       <= rd_in_range && pal_vld_ff[rd_addr];
         b_lut_ff       <= is_lut;
         b_pix_ff       <= pix;
         b_row_end_ff   <= row_end;
         b_burst_end_ff <= burst_end;
      end
   end

   // unwritten or out-of-range entries read as black
   always_comb begin
      lut_rgb            = rd_ok_ff ? rd_ff : 24'b0;
      rsp_valid          = b_vld_ff;
      rsp_data.red       = b_lut_ff ? lut_rgb[23:16] : b_pix_ff[31:24];
      rsp_data.green     = b_lut_ff ? lut_rgb[15:8]  : b_pix_ff[23:16];
      rsp_data.blue      = b_lut_ff ? lut_rgb[7:0]   : b_pix_ff[15:8];
      rsp_data.alpha     = b_pix_ff[7:0];
      rsp_data.row_end   = b_row_end_ff;
      rsp_data.burst_end = b_burst_end_ff;
   end

endmodule

// File: dv/tb_png_scanline_pixel_unpack_core.sv
// Testbench for png_scanline_pixel_unpack_core: directed table, then random scanlines.
`timescale 1ns / 100ps

// Stimulus comes in two parts. A short table of directed transactions comes first:
// reset values, sample extremes, every color mode and depth, palette lookups of written
// and unwritten entries, tail bits dropped at the row end, and unsupported combinations.
// Random scanline phases follow, each under its own register setting.
// Every accepted request runs through a local unpacker model that queues the pixels it
// should produce. Each accepted result transaction is compared field by field with the
// oldest queued pixel.
module tb_png_scanline_pixel_unpack_core;
   import pngunp_pkg::*;

   localparam int         DRAIN_CYCLES = 64;    // 4-deep queue, up to 8 pixels per byte
   localparam int         NUM_PHASES   = 14;
   localparam logic [2:0] MODE_BAD     = 3'd7;  // not a color mode at all
   localparam logic [2:0] DEPTH_BAD    = 3'd6;  // not a depth code at all

   typedef struct {
      logic [2:0]  mode;
      logic [2:0]  depth;
      logic [12:0] width;
      int          items;
   } line_setup_type;

   typedef struct {
      logic           new_cfg;   // drain, then reprogram before this transaction
      logic [2:0]     mode;
      logic [2:0]     depth;
      logic [12:0]    width;
      pngunp_req_type item;
      logic           typed;     // expected pixel given in the row itself
      pngunp_rsp_type px;
   } smoke_row_type;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   pngunp_req_type req_data  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   pngunp_rsp_type rsp_data;
   logic           psel      = 1'b0;
   logic           penable   = 1'b0;
   logic           pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr  = '0;
   logic [31:0]    pwdata    = '0;
   logic [31:0]    prdata;
   logic           pready;

   // Unpacker model state
   logic [23:0]    pal_mem [256];
   logic [55:0]    gather_hold;
   logic [2:0]     gather_cnt;
   logic [12:0]    col_cnt;
   logic [2:0]     cfg_mode;
   logic [2:0]     cfg_depth;
   logic [12:0]    cfg_width;

   pngunp_rsp_type pixel_out[$];       // pixels caused by the latest transaction
   pngunp_rsp_type pending_pixels[$];  // pixels the block still owes us
   smoke_row_type  smoke_rows[$];
   line_setup_type plan [NUM_PHASES];

   int             mismatch_count = 0;
   int unsigned    send_idle_pct  = 32;
   int unsigned    rcv_idle_pct   = 66;
   pngunp_rsp_type want;

   png_scanline_pixel_unpack_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   // Appends one pixel and advances the column; returns 1 when the row has ended.
   function automatic logic emit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a);
      pngunp_rsp_type px;
      int unsigned    w;
      logic           ended;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      col_cnt = col_cnt + 13'd1;
      ended   = (col_cnt >= w);
      if (ended) col_cnt = '0;
      px.red       = r;
      px.green     = g;
      px.blue      = b;
      px.alpha     = a;
      px.row_end   = ended;
      px.burst_end = 1'b0;
      pixel_out.push_back(px);
      return ended;
   endfunction

   // Works out the pixels one request transaction causes; leaves them in pixel_out.
   function automatic void unpack_byte(input pngunp_req_type it);
      int unsigned d, per, nch, bs, bpp, k, c, lvl;
      logic [7:0]  smp;
      logic [7:0]  v [4];
      logic [63:0] seq;
      logic [15:0] w16;
      logic [23:0] ent;
      logic        stop;
      pixel_out.delete();
      if (it.kind == KIND_PAL_WRITE) begin
         pal_mem[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
         return;
      end
      if (cfg_mode > MODE_RGBA || cfg_depth > DEPTH_16) return;

      if (cfg_depth < DEPTH_8) begin
         // packed samples, MSB first; stop at the row end and drop the tail bits
         if (cfg_mode != MODE_GREY && cfg_mode != MODE_PALETTE) return;
         d    = 1 << cfg_depth;
         per  = 8 / d;
         stop = 1'b0;
         for (k = 0; k < per && !stop; k++) begin
            smp = 8'((int'(it.data_byte) >> (8 - d * (k + 1))) & ((1 << d) - 1));
            if (cfg_mode == MODE_GREY) begin
               lvl  = (d == 1) ? smp * 255 : (d == 2) ? smp * 85 : smp * 17;
               stop = emit_pixel(8'(lvl), 8'(lvl), 8'(lvl), 8'hFF);
            end else begin
               ent  = pal_mem[smp];
               stop = emit_pixel(ent[23:16], ent[15:8], ent[7:0], 8'hFF);
            end
         end
      end else begin
         case (cfg_mode)
            MODE_GREY_ALPHA: nch = 2;
            MODE_RGB:        nch = 3;
            MODE_RGBA:       nch = 4;
            default:         nch = 1;
         endcase
         bs = (cfg_depth == DEPTH_16) ? 2 : 1;
         if (cfg_mode == MODE_PALETTE && bs == 2) return;
         bpp = nch * bs;
         if (int'(gather_cnt) + 1 < bpp) begin
            gather_hold = {gather_hold[47:0], it.data_byte};
            gather_cnt  = gather_cnt + 3'd1;
            return;
         end
         seq         = {gather_hold, it.data_byte};
         gather_hold = '0;
         gather_cnt  = '0;
         for (c = 0; c < 4; c++) v[c] = 8'h00;
         for (c = 0; c < nch; c++) begin
            if (bs == 1) begin
               v[c] = 8'(seq >> (8 * (bpp - 1 - c)));
            end else begin
               w16  = 16'(seq >> (16 * (nch - 1 - c)));
               v[c] = 8'(w16 / 16'd257);   // big-endian sample scaled to 8 bits
            end
         end
         case (cfg_mode)
            MODE_GREY:       stop = emit_pixel(v[0], v[0], v[0], 8'hFF);
            MODE_GREY_ALPHA: stop = emit_pixel(v[0], v[0], v[0], v[1]);
            MODE_PALETTE: begin
               ent  = pal_mem[v[0]];
               stop = emit_pixel(ent[23:16], ent[15:8], ent[7:0], 8'hFF);
            end
            MODE_RGB:        stop = emit_pixel(v[0], v[1], v[2], 8'hFF);
            default:         stop = emit_pixel(v[0], v[1], v[2], v[3]);
         endcase
      end
      if (pixel_out.size() > 0) pixel_out[pixel_out.size() - 1].burst_end = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, int unsigned want_v,
                                       int unsigned got_v);
      if (want_v != got_v) begin
         $error("pixel %s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel transaction with no expectation: 0x%0h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("red",       want.red,       rsp_data.red);
            check_field("green",     want.green,     rsp_data.green);
            check_field("blue",      want.blue,      rsp_data.blue);
            check_field("alpha",     want.alpha,     rsp_data.alpha);
            check_field("row_end",   want.row_end,   rsp_data.row_end);
            check_field("burst_end", want.burst_end, rsp_data.burst_end);
         end
      end
   end

   // Result side back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
   end

   // ---------------------------------------------------------------- drivers

   function automatic pngunp_req_type data_req(logic [7:0] b);
      pngunp_req_type it;
      it           = '0;
      it.kind      = KIND_DATA;
      it.data_byte = b;
      return it;
   endfunction

   function automatic pngunp_req_type pal_req(logic [7:0] idx, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b);
      pngunp_req_type it;
      it           = '0;
      it.kind      = KIND_PAL_WRITE;
      it.pal_index = idx;
      it.pal_red   = r;
      it.pal_green = g;
      it.pal_blue  = b;
      return it;
   endfunction

   function automatic pngunp_rsp_type pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a, logic re, logic be);
      return {r, g, b, a, re, be};
   endfunction

   // Mostly scanline bytes with some palette writes; every field random, data bytes biased to 0x00/0xFF.
   function automatic pngunp_req_type random_req(logic pal_heavy);
      pngunp_req_type it;
      it.kind      = ($urandom_range(99) < (pal_heavy ? 15 : 5)) ? KIND_PAL_WRITE
                                                                 : KIND_DATA;
      it.data_byte = 8'($urandom_range(255));
      it.pal_index = 8'($urandom_range(255));
      it.pal_red   = 8'($urandom_range(255));
      it.pal_green = 8'($urandom_range(255));
      it.pal_blue  = 8'($urandom_range(255));
      if ($urandom_range(7) == 0) it.data_byte = $urandom_range(1) ? 8'hFF : 8'h00;
      return it;
   endfunction

   task automatic add_row(input logic cfg, input logic [2:0] m, input logic [2:0] d,
                          input logic [12:0] w, input pngunp_req_type it,
                          input logic typed, input pngunp_rsp_type px);
      smoke_row_type row;
      row.new_cfg = cfg;
      row.mode    = m;
      row.depth   = d;
      row.width   = w;
      row.item    = it;
      row.typed   = typed;
      row.px      = px;
      smoke_rows.push_back(row);
   endtask

   // Entered and left at a falling edge. Holds valid and payload until accepted.
   task automatic send_item(input pngunp_req_type it, input logic typed,
                            input pngunp_rsp_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      unpack_byte(it);
      if (typed) pending_pixels.push_back(px);
      else foreach (pixel_out[i]) pending_pixels.push_back(pixel_out[i]);
      @(negedge clock);
   endtask

   // Register write: setup, then access, then idle.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_COLOR_MODE: cfg_mode  = val[2:0];
         REG_DEPTH_CODE: cfg_depth = val[2:0];
         REG_ROW_WIDTH:  cfg_width = val[12:0];
         default: ;
      endcase
      // any register write restarts the scanline
      gather_hold = '0;
      gather_cnt  = '0;
      col_cnt     = '0;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Stop sending and wait for every owed pixel to come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   // Registers change only with the block idle. Bytes that end no pixel leave nothing
   // to wait for, so give the queue and back end time to empty on top of that.
   task automatic load_config(input logic [2:0] m, input logic [2:0] d,
                              input logic [12:0] w);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write(REG_COLOR_MODE, 32'(m));
      csr_write(REG_DEPTH_CODE, 32'(d));
      csr_write(REG_ROW_WIDTH,  32'(w));
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int ph;
      int n;
      logic pal_heavy;

      foreach (pal_mem[i]) pal_mem[i] = '0;
      gather_hold = '0;
      gather_cnt  = '0;
      col_cnt     = '0;
      cfg_mode    = MODE_GREY;
      cfg_depth   = DEPTH_8;
      cfg_width   = 13'd1;

      // Directed table. Pixels typed in only where obvious; others go to the model.
      // Reset setting is 8-bit grey, one pixel per row: sample extremes.
      add_row(0, 0, 0, 0, data_req(8'h00), 1, pix(8'h00, 8'h00, 8'h00, 8'hFF, 1, 1));
      add_row(0, 0, 0, 0, data_req(8'hFF), 1, pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1));
      // palette writes produce nothing
      add_row(0, 0, 0, 0, pal_req(8'h00, 8'h01, 8'h02, 8'h03), 0, '0);
      add_row(0, 0, 0, 0, pal_req(8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0);
      add_row(0, 0, 0, 0, pal_req(8'h5A, 8'h12, 8'h34, 8'h56), 0, '0);
      // 8-bit palette: a written entry, then one never written (reads zero)
      add_row(1, MODE_PALETTE, DEPTH_8, 13'd2, data_req(8'h5A), 1,
              pix(8'h12, 8'h34, 8'h56, 8'hFF, 0, 1));
      add_row(0, 0, 0, 0, data_req(8'h01), 1, pix(8'h00, 8'h00, 8'h00, 8'hFF, 1, 1));
      // 1-bit grey, row of 5: three tail bits dropped in every byte
      add_row(1, MODE_GREY, DEPTH_1, 13'd5, data_req(8'hA5), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'hFF), 0, '0);
      // 2-bit grey, row of 3
      add_row(1, MODE_GREY, DEPTH_2, 13'd3, data_req(8'hE4), 0, '0);
      // 4-bit and 1-bit palette lookups, widest row
      add_row(1, MODE_PALETTE, DEPTH_4, 13'd4096, data_req(8'h0F), 0, '0);
      add_row(1, MODE_PALETTE, DEPTH_1, 13'd8, data_req(8'h80), 0, '0);
      // 8-bit grey+alpha: second byte closes the pixel
      add_row(1, MODE_GREY_ALPHA, DEPTH_8, 13'd1, data_req(8'h12), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h34), 1, pix(8'h12, 8'h12, 8'h12, 8'h34, 1, 1));
      // 8-bit RGBA, row of 2
      add_row(1, MODE_RGBA, DEPTH_8, 13'd2, data_req(8'h11), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h22), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h33), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h44), 1, pix(8'h11, 8'h22, 8'h33, 8'h44, 0, 1));
      // 16-bit grey+alpha: full scale and zero
      add_row(1, MODE_GREY_ALPHA, DEPTH_16, 13'd1, data_req(8'hFF), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'hFF), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h00), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h00), 1, pix(8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 1));
      // unsupported: RGB at 1 bit, and a mode code past the last one
      add_row(1, MODE_RGB, DEPTH_1, 13'd1, data_req(8'h55), 0, '0);
      add_row(1, MODE_BAD, DEPTH_8, 13'd1, data_req(8'h55), 0, '0);
      // 16-bit grey, 0x8080 / 257 = 128
      add_row(1, MODE_GREY, DEPTH_16, 13'd1, data_req(8'h80), 0, '0);
      add_row(0, 0, 0, 0, data_req(8'h80), 1, pix(8'h80, 8'h80, 8'h80, 8'hFF, 1, 1));

      // Random phases. Width 0 acts as 1 and 8191 as the maximum.
      plan = '{
         '{MODE_GREY,       DEPTH_1,  13'd13,   12},
         '{MODE_PALETTE,    DEPTH_2,  13'd4096, 12},
         '{MODE_GREY_ALPHA, DEPTH_16, 13'd3,    12},
         '{MODE_RGB,        DEPTH_8,  13'd0,    12},
         '{MODE_PALETTE,    DEPTH_4,  13'd5,    12},
         '{MODE_RGBA,       DEPTH_16, 13'd2,    12},
         '{MODE_GREY,       DEPTH_2,  13'd8191, 12},
         '{MODE_GREY,       DEPTH_16, 13'd7,    12},
         '{MODE_PALETTE,    DEPTH_8,  13'd9,    12},
         '{MODE_RGBA,       DEPTH_8,  13'd1,    12},
         '{MODE_GREY,       DEPTH_4,  13'd6,    12},
         '{MODE_RGB,        DEPTH_16, 13'd4,    12},
         '{MODE_PALETTE,    DEPTH_16, 13'd1,    4},   // unsupported pairing
         '{MODE_BAD,        DEPTH_BAD, 13'd1,   4}    // out-of-range codes
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (smoke_rows[i]) begin
         if (smoke_rows[i].new_cfg)
            load_config(smoke_rows[i].mode, smoke_rows[i].depth, smoke_rows[i].width);
         send_item(smoke_rows[i].item, smoke_rows[i].typed, smoke_rows[i].px);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         // receiver-light first, then sender-light, then full rate
         if (ph < 4) begin
            send_idle_pct = 32;
            rcv_idle_pct  = 66;
         end else if (ph < 8) begin
            send_idle_pct = 66;
            rcv_idle_pct  = 32;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         load_config(plan[ph].mode, plan[ph].depth, plan[ph].width);
         pal_heavy = (plan[ph].mode == MODE_PALETTE);
         for (n = 0; n < plan[ph].items; n++) begin
            // hold off mid-line once until the block has caught up
            if (ph == 5 && n == 8) wait_drained();
            send_item(random_req(pal_heavy), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
